// File: rtl/u16550_pkg.sv
// Shared types, register codes and interrupt helpers for the 16550-style register block.
// No dependencies; u16550_regs and the top level import this package.
`timescale 1ns / 1ps

package u16550_pkg;

	typedef enum logic [1:0] {
		REQ_READ,
		REQ_WRITE,
		REQ_EVENT,
		REQ_DSR_TICK
	} req_kind_t;

	typedef enum logic [2:0] {
		REG_DATA,
		REG_IER,
		REG_IIR_FCR,
		REG_LCR,
		REG_MCR,
		REG_LSR,
		REG_MSR,
		REG_SCR
	} reg_addr_t;

	// Interrupt source bits in the pending mask
	localparam logic [3:0] SRC_RX    = 4'h1;
	localparam logic [3:0] SRC_TX    = 4'h2;
	localparam logic [3:0] SRC_MODEM = 4'h8;

	// IIR codes
	localparam logic [7:0] IIR_RX    = 8'h04;
	localparam logic [7:0] IIR_TX    = 8'h02;
	localparam logic [7:0] IIR_MODEM = 8'h00;
	localparam logic [7:0] IIR_NONE  = 8'h01;

	localparam logic [7:0] MCR_MASK  = 8'h3F;
	localparam logic [7:0] LSR_DR    = 8'h01;
	localparam logic [7:0] LSR_THRE  = 8'h60;
	localparam logic [7:0] LSR_KEEP  = 8'hF0;
	localparam logic [7:0] MSR_KEEP  = 8'hF0;
	localparam logic [7:0] MSR_DSR   = 8'h20;
	localparam logic [7:0] MSR_DDSR  = 8'h02;
	localparam int         LCR_DLAB  = 7;
	localparam int         LSR_DR_BIT   = 0;
	localparam int         LSR_THRE_BIT = 5;

	typedef struct packed {
		req_kind_t  kind;
		reg_addr_t  addr;
		logic [7:0] wdata;
		logic       rx_rdy;
		logic       tx_rdy;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_taken;
		logic       irq_pending;
	} rsp_t;

	typedef struct packed {
		logic [3:0] pend;
		logic [7:0] ident;
		logic [3:0] line;
	} intr_t;

	// Re-encode IIR by priority; latch the line on the first pending source.
	function automatic intr_t intr_update(intr_t s);
		intr_t r;
		r = s;
		if (r.pend[0]) begin
			r.ident = IIR_RX;
		end else if (r.pend[1]) begin
			r.ident = IIR_TX;
		end else if (r.pend[3]) begin
			r.ident = IIR_MODEM;
		end else begin
			r.ident = IIR_NONE;
			r.line  = 4'h0;
		end
		if ((r.pend != 4'h0) && (r.line == 4'h0)) begin
			r.line = r.pend;
		end
		return r;
	endfunction

	function automatic intr_t intr_raise(intr_t s, logic [7:0] ier, logic [3:0] src);
		intr_t r;
		r = s;
		if (((s.pend & src) == 4'h0) && ((ier[3:0] & src) != 4'h0)) begin
			r.pend = s.pend | src;
			r = intr_update(r);
		end
		return r;
	endfunction

	function automatic intr_t intr_clear(intr_t s, logic [3:0] src);
		intr_t r;
		r = s;
		if ((s.pend & src) != 4'h0) begin
			r.pend = s.pend & ~src;
			r = intr_update(r);
		end
		return r;
	endfunction

endpackage

// File: rtl/u16550_if.sv
// Valid/ready channel interfaces for the request and response items.
// No dependencies.
`timescale 1ns / 1ps

interface u16550_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] addr;
	logic [7:0] wdata;
	logic       host_rx_ready;
	logic       host_tx_ready;
	logic [7:0] host_rx_byte;

	modport source (
		output valid, req_type, addr, wdata, host_rx_ready, host_tx_ready, host_rx_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, addr, wdata, host_rx_ready, host_tx_ready, host_rx_byte,
		output ready
	);
endinterface

interface u16550_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rdata;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       rx_taken;
	logic       irq_pending;

	modport source (
		output valid, rdata, tx_valid, tx_byte, rx_taken, irq_pending,
		input  ready
	);
	modport sink (
		input  valid, rdata, tx_valid, tx_byte, rx_taken, irq_pending,
		output ready
	);
endinterface

// File: rtl/u16550_regs.sv
// Register file and interrupt logic: one item is applied per step.
// Depends on u16550_pkg.
`timescale 1ns / 1ps

module u16550_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              input_en,
	input  logic              step,
	input  u16550_pkg::req_t  item,
	output u16550_pkg::rsp_t  result
);
	import u16550_pkg::*;

	logic [7:0] ier_q, lcr_q, mcr_q, lsr_q, msr_q, scr_q, dll_q, dlm_q;
	intr_t      int_q;

	logic [7:0] ier_d, lcr_d, mcr_d, lsr_d, msr_d, scr_d, dll_d, dlm_d;
	intr_t      int_d;
	logic [7:0] lsr_live;
	logic [7:0] lsr_rise;
	logic       dlab;

	assign dlab = lcr_q[LCR_DLAB];

	always_comb begin
		ier_d    = ier_q;
		lcr_d    = lcr_q;
		mcr_d    = mcr_q;
		lsr_d    = lsr_q;
		msr_d    = msr_q;
		scr_d    = scr_q;
		dll_d    = dll_q;
		dlm_d    = dlm_q;
		int_d    = int_q;
		lsr_live = (item.rx_rdy ? LSR_DR : 8'h00) | (item.tx_rdy ? LSR_THRE : 8'h00);
		lsr_rise = 8'h00;
		result   = '{rdata: 8'hFF, tx_valid: 1'b0, tx_byte: 8'h00,
			rx_taken: 1'b0, irq_pending: 1'b0};

		case (item.kind)
			REQ_READ: begin
				case (item.addr)
					REG_DATA: begin
						if (dlab) begin
							result.rdata = dll_q;
						end else begin
							int_d = intr_clear(int_q, SRC_RX);
							if (input_en) begin
								result.rdata    = item.rx_byte;
								result.rx_taken = 1'b1;
							end
						end
					end
					REG_IER:     result.rdata = dlab ? dlm_q : ier_q;
					REG_IIR_FCR: result.rdata = int_q.ident;
					REG_LCR:     result.rdata = lcr_q;
					REG_MCR:     result.rdata = mcr_q;
					REG_LSR: begin
						result.rdata = lsr_live;
						lsr_d        = lsr_live & LSR_KEEP;
					end
					REG_MSR: begin
						result.rdata = msr_q;
						msr_d        = msr_q & MSR_KEEP;
						int_d        = intr_clear(int_q, SRC_MODEM);
					end
					default:     result.rdata = scr_q;
				endcase
			end
			REQ_WRITE: begin
				case (item.addr)
					REG_DATA: begin
						if (dlab) begin
							dll_d = item.wdata;
						end else begin
							result.tx_valid = 1'b1;
							result.tx_byte  = item.wdata;
							int_d = intr_raise(intr_clear(int_q, SRC_TX), ier_q, SRC_TX);
						end
					end
					REG_IER: begin
						if (dlab) begin
							dlm_d = item.wdata;
						end else begin
							ier_d = item.wdata;
						end
					end
					// FCR is write-only and drives nothing here
					REG_IIR_FCR: begin
					end
					REG_LCR: lcr_d = item.wdata;
					REG_MCR: mcr_d = item.wdata & MCR_MASK;
					REG_LSR, REG_MSR: begin
					end
					default: scr_d = item.wdata;
				endcase
			end
			REQ_EVENT: begin
				lsr_d = lsr_q | ((item.rx_rdy && input_en) ? LSR_DR : 8'h00)
					| (item.tx_rdy ? LSR_THRE : 8'h00);
				lsr_rise = lsr_d & ~lsr_q;
				if (lsr_rise[LSR_DR_BIT]) begin
					int_d = intr_raise(int_d, ier_q, SRC_RX);
				end
				if (lsr_rise[LSR_THRE_BIT]) begin
					int_d = intr_raise(int_d, ier_q, SRC_TX);
				end
			end
			default: begin
				msr_d = (msr_q ^ MSR_DSR) | MSR_DDSR;
				int_d = intr_raise(int_q, ier_q, SRC_MODEM);
			end
		endcase

		result.irq_pending = (int_d.line != 4'h0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q <= '0;
			lcr_q <= '0;
			mcr_q <= '0;
			lsr_q <= '0;
			msr_q <= '0;
			scr_q <= '0;
			dll_q <= '0;
			dlm_q <= '0;
			int_q <= '0;
		end else if (step) begin
			ier_q <= ier_d;
			lcr_q <= lcr_d;
			mcr_q <= mcr_d;
			lsr_q <= lsr_d;
			msr_q <= msr_d;
			scr_q <= scr_d;
			dll_q <= dll_d;
			dlm_q <= dlm_d;
			int_q <= int_d;
		end
	end

	a_line_tracks_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(int_q.pend != 4'h0) == (int_q.line != 4'h0))
		else $error("interrupt line out of step with pending sources");

	a_ident_rx: assert property (@(posedge clk) disable iff (!arst_n)
		int_q.pend[0] |-> (int_q.ident == IIR_RX))
		else $error("IIR does not show receive priority");

	a_ident_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(!int_q.pend[0] && int_q.pend[1]) |-> (int_q.ident == IIR_TX))
		else $error("IIR does not show THR-empty priority");

	a_no_stray_src: assert property (@(posedge clk) disable iff (!arst_n)
		(int_q.pend[2] == 1'b0) && (lsr_q[4:1] == 4'h0) && (lsr_q[7] == 1'b0))
		else $error("undefined pending or LSR bit set");

	a_tick_sets_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (item.kind == REQ_DSR_TICK)) |=> msr_q[1])
		else $error("DSR tick did not set delta bit");

endmodule

// File: rtl/uart_16550_register_model_top.sv
// Top level of the 16550-style UART register block: channel registers around the register file.
// Depends on u16550_pkg, u16550_if (request/response interfaces) and u16550_regs.
`timescale 1ns / 1ps

// Usage
//   req: one item per handshake, a bus read, a bus write, a host status event or a
//        DSR timer tick (req_type), with offset, write byte and host receive state.
//   rsp: one item per request, in order: read data (0xFF for anything but a read),
//        transmitted byte with its flag, receive-consumed flag and the interrupt level
//        after the request.
//   cfg_we/cfg_wdata: write input_enabled; write only while no request is in flight.
// Timing
//   An accepted request is held in the input stage, is applied to the register file in
//   the cycle that it advances and its response is loaded into the output register at
//   that edge, where it is offered until taken. Throughput is one request per cycle
//   while rsp does not stall; the register file's single read-modify-write per cycle
//   sets that rate.
// Reset
//   arst_n clears the register file, input_enabled and both stage valid flags; IIR reads 0x00 until
//   the first interrupt source change.
// Backpressure
//   When rsp stalls, hold the response; the input stage still takes one more request,
//   then req.ready drops until the response register frees.
module uart_16550_register_model_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	u16550_req_if.sink         req,
	u16550_rsp_if.source       rsp
);
	import u16550_pkg::*;

	logic input_en_q;
	logic valid_s1;
	req_t item_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	rsp_t result;
	logic advance;

	// Move the input stage forward when the response register is free or draining.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_en_q <= 1'b0;
		end else if (cfg_we) begin
			input_en_q <= cfg_wdata;
		end
	end

	// Input stage: hold the accepted request until it is applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{kind: req_kind_t'(req.req_type), addr: reg_addr_t'(req.addr),
				wdata: req.wdata, rx_rdy: req.host_rx_ready, tx_rdy: req.host_tx_ready,
				rx_byte: req.host_rx_byte};
		end
	end

	// Apply the request to the registers exactly once, on advance.
	u16550_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.input_en (input_en_q),
		.step     (advance),
		.item     (item_s1),
		.result   (result)
	);

	// Output stage: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.rdata       = rsp_s2.rdata;
	assign rsp.tx_valid    = rsp_s2.tx_valid;
	assign rsp.tx_byte     = rsp_s2.tx_byte;
	assign rsp.rx_taken    = rsp_s2.rx_taken;
	assign rsp.irq_pending = rsp_s2.irq_pending;

endmodule
